>>> sv/mpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpp_pkg;

    // sizing
    localparam int MAX_SEGMENTS = 64;
    localparam int URI_BYTES    = 256;

    localparam int LEN_HEADER  = 7;
    localparam int LEN_VERSION = 15;
    localparam int LEN_TARGET  = 22;
    localparam int LEN_INF     = 8;
    localparam int LEN_END     = 14;

    // widest column the parser must count to
    localparam int COL_MAX = (URI_BYTES - 1 > LEN_TARGET) ? URI_BYTES - 1 : LEN_TARGET;
    localparam int COL_W   = $clog2(COL_MAX + 1);
    localparam int SEG_W   = $clog2(MAX_SEGMENTS + 1);

    localparam logic [7:0] CHAR_LF   = 8'h0a;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // tag texts, first character in the top byte
    localparam logic [8*LEN_HEADER-1:0]  TXT_HEADER  = "#EXTM3U";
    localparam logic [8*LEN_VERSION-1:0] TXT_VERSION = "#EXT-X-VERSION:";
    localparam logic [8*LEN_TARGET-1:0]  TXT_TARGET  = "#EXT-X-TARGETDURATION:";
    localparam logic [8*LEN_INF-1:0]     TXT_INF     = "#EXTINF:";
    localparam logic [8*LEN_END-1:0]     TXT_END     = "#EXT-X-ENDLIST";

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_VERSION  = 3'd1,
        PH_TARGET   = 3'd2,
        PH_TAG      = 3'd3,
        PH_DURATION = 3'd4,
        PH_URI      = 3'd5,
        PH_DONE     = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        KIND_VERSION  = 3'd0,
        KIND_TARGET   = 3'd1,
        KIND_DURATION = 3'd2,
        KIND_URI_BYTE = 3'd3,
        KIND_VERDICT  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic        accepted;
    } out_item_t;

    // character lookups, zero past the end of the text
    function automatic logic [7:0] header_char(input logic [4:0] idx);
        if (int'(idx) < LEN_HEADER) begin
            return TXT_HEADER[8*(LEN_HEADER-1-int'(idx)) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] version_char(input logic [4:0] idx);
        if (int'(idx) < LEN_VERSION) begin
            return TXT_VERSION[8*(LEN_VERSION-1-int'(idx)) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] target_char(input logic [4:0] idx);
        if (int'(idx) < LEN_TARGET) begin
            return TXT_TARGET[8*(LEN_TARGET-1-int'(idx)) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] inf_char(input logic [4:0] idx);
        if (int'(idx) < LEN_INF) begin
            return TXT_INF[8*(LEN_INF-1-int'(idx)) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] end_char(input logic [4:0] idx);
        if (int'(idx) < LEN_END) begin
            return TXT_END[8*(LEN_END-1-int'(idx)) +: 8];
        end
        return 8'h00;
    endfunction

endpackage

`default_nettype wire

>>> sv/media_playlist_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Media playlist parser: takes one playlist byte per transfer and emits at most one
// result in the cycle after it (version, target duration, segment duration, URI byte, or
// the verdict on the byte flagged last). A byte is taken in every cycle unless the
// result register holds an untaken result and m_ready is low; the rate is one byte
// per cycle while no result stalls, set by the combinational parser state update
// (prefix compare and a times-ten accumulate with 32-bit overflow check). After the
// verdict the parser returns to its reset state, so the next byte starts a new
// playlist. No clearing pass is needed after reset.
module media_playlist_parser_core (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire mpp_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire                      m_ready,
    output mpp_pkg::out_item_t       m_data
);
    import mpp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [31:0]       acc_reg, acc_next;
    logic              digit_seen_reg, digit_seen_next;
    logic [1:0]        cand_reg, cand_next;      // bit 0 EXTINF, bit 1 ENDLIST
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic              failed_reg, failed_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic              take;
    logic [7:0]        b;
    logic              is_lf;
    logic              num_char;
    logic [3:0]        digit;
    logic [35:0]       acc_sum;
    logic              acc_ovf;
    logic [COL_W-1:0]  pfx_len;
    logic [7:0]        pfx_char;
    logic              in_prefix;
    logic              num_fail;
    logic              num_done;
    logic              inf_ok;
    logic              end_ok;
    logic [COL_W-1:0]  col_inc;
    logic [SEG_W-1:0]  seg_inc;
    logic              emit;
    kind_t             emit_kind;
    logic [31:0]       emit_value;
    logic              vd_ok;
    logic [SEG_W-1:0]  vd_seg;
    logic              vd_failed;
    phase_t            vd_phase;

    assign take    = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // byte decode and decimal accumulate
    assign b        = s_data.data_byte;
    assign is_lf    = (b == CHAR_LF);
    assign num_char = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign digit    = 4'(b - CHAR_ZERO);
    assign acc_sum  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {32'd0, digit};
    assign acc_ovf  = |acc_sum[35:32];
    assign col_inc  = col_reg + COL_W'(1);
    assign seg_inc  = seg_reg + SEG_W'(1);

    // prefix of the numeric line being read
    always_comb begin
        case (phase_reg)
            PH_VERSION: begin
                pfx_len  = COL_W'(LEN_VERSION);
                pfx_char = version_char(col_reg[4:0]);
            end
            PH_TARGET: begin
                pfx_len  = COL_W'(LEN_TARGET);
                pfx_char = target_char(col_reg[4:0]);
            end
            default: begin
                pfx_len  = COL_W'(LEN_INF);
                pfx_char = inf_char(col_reg[4:0]);
            end
        endcase
    end

    assign in_prefix = (col_reg < pfx_len);
    assign num_fail  = in_prefix ? (b != pfx_char)
                     : (is_lf ? !digit_seen_reg : (!num_char || acc_ovf));
    assign num_done  = !in_prefix && is_lf && digit_seen_reg;

    // tag candidates still matching
    assign inf_ok = cand_reg[0] && (col_reg < COL_W'(LEN_INF)) && (b == inf_char(col_reg[4:0]));
    assign end_ok = cand_reg[1] && (col_reg < COL_W'(LEN_END)) && (b == end_char(col_reg[4:0]));

    // next parser state
    always_comb begin
        phase_next      = phase_reg;
        col_next        = col_reg;
        acc_next        = acc_reg;
        digit_seen_next = digit_seen_reg;
        cand_next       = cand_reg;
        seg_next        = seg_reg;
        failed_next     = failed_reg;
        if (take) begin
            if (!failed_reg) begin
                case (phase_reg)
                    PH_HEADER: begin
                        if (is_lf) begin
                            if (col_reg == COL_W'(LEN_HEADER)) begin
                                phase_next = PH_VERSION;
                                col_next   = '0;
                            end else begin
                                failed_next = 1'b1;
                            end
                        end else if ((col_reg < COL_W'(LEN_HEADER)) &&
                                     (b == header_char(col_reg[4:0]))) begin
                            col_next = col_inc;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_VERSION, PH_TARGET, PH_DURATION: begin
                        if (num_fail) begin
                            failed_next = 1'b1;
                        end else if (num_done) begin
                            phase_next      = (phase_reg == PH_VERSION) ? PH_TARGET
                                            : (phase_reg == PH_TARGET) ? PH_TAG : PH_URI;
                            col_next        = '0;
                            acc_next        = '0;
                            digit_seen_next = 1'b0;
                            cand_next       = 2'b11;
                        end else if (in_prefix) begin
                            col_next = col_inc;
                        end else begin
                            acc_next        = acc_sum[31:0];
                            digit_seen_next = 1'b1;
                        end
                    end
                    PH_TAG: begin
                        if (is_lf) begin
                            if (cand_reg[1] && (col_reg == COL_W'(LEN_END))) begin
                                phase_next = PH_DONE;
                                col_next   = '0;
                                cand_next  = 2'b11;
                            end else begin
                                failed_next = 1'b1;
                            end
                        end else begin
                            cand_next = {end_ok, inf_ok};
                            if (!inf_ok && !end_ok) begin
                                failed_next = 1'b1;
                            end else begin
                                col_next = col_inc;
                                if (inf_ok && (col_inc == COL_W'(LEN_INF))) begin
                                    phase_next      = PH_DURATION;
                                    acc_next        = '0;
                                    digit_seen_next = 1'b0;
                                end
                            end
                        end
                    end
                    PH_URI: begin
                        if (is_lf) begin
                            seg_next   = seg_inc;
                            phase_next = (seg_inc >= SEG_W'(MAX_SEGMENTS)) ? PH_DONE : PH_TAG;
                            col_next   = '0;
                            cand_next  = 2'b11;
                        end else if (col_reg >= COL_W'(URI_BYTES - 1)) begin
                            failed_next = 1'b1;
                        end else begin
                            col_next = col_inc;
                        end
                    end
                    default: begin
                        failed_next = 1'b1;
                    end
                endcase
            end
            // the last byte closes the playlist and restarts the parser
            if (s_data.is_last) begin
                phase_next      = PH_HEADER;
                col_next        = '0;
                acc_next        = '0;
                digit_seen_next = 1'b0;
                cand_next       = 2'b11;
                seg_next        = '0;
                failed_next     = 1'b0;
            end
        end
    end

    // result decode
    always_comb begin
        emit       = 1'b0;
        emit_kind  = KIND_VERSION;
        emit_value = acc_reg;
        if (!failed_reg) begin
            case (phase_reg)
                PH_VERSION, PH_TARGET, PH_DURATION: begin
                    emit      = !num_fail && num_done;
                    emit_kind = (phase_reg == PH_VERSION) ? KIND_VERSION
                              : (phase_reg == PH_TARGET) ? KIND_TARGET : KIND_DURATION;
                end
                PH_URI: begin
                    emit       = !is_lf && (col_reg < COL_W'(URI_BYTES - 1));
                    emit_kind  = KIND_URI_BYTE;
                    emit_value = {24'd0, b};
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (take) begin
            m_valid_next = s_data.is_last || emit;
            if (s_data.is_last) begin
                m_data_next.kind     = KIND_VERDICT;
                m_data_next.value    = vd_ok ? {{(32-SEG_W){1'b0}}, vd_seg} : 32'd0;
                m_data_next.accepted = vd_ok;
            end else begin
                m_data_next.kind     = emit_kind;
                m_data_next.value    = emit_value;
                m_data_next.accepted = 1'b0;
            end
        end
    end

    // verdict from the pre-restart state of this byte
    always_comb begin
        vd_failed = failed_reg;
        vd_phase  = phase_reg;
        vd_seg    = seg_reg;
        if (!failed_reg) begin
            case (phase_reg)
                PH_HEADER: begin
                    vd_failed = !(!is_lf && (col_reg < COL_W'(LEN_HEADER)) &&
                                  (b == header_char(col_reg[4:0]))) &&
                                !(is_lf && (col_reg == COL_W'(LEN_HEADER)));
                    vd_phase  = (is_lf && (col_reg == COL_W'(LEN_HEADER))) ? PH_VERSION
                                                                             : PH_HEADER;
                end
                PH_VERSION, PH_TARGET, PH_DURATION: begin
                    vd_failed = num_fail;
                    vd_phase  = num_done ? PH_TAG : phase_reg;
                end
                PH_TAG: begin
                    vd_failed = is_lf ? !(cand_reg[1] && (col_reg == COL_W'(LEN_END)))
                                      : (!inf_ok && !end_ok);
                    vd_phase  = (is_lf && cand_reg[1] && (col_reg == COL_W'(LEN_END)))
                              ? PH_DONE : PH_TAG;
                end
                PH_URI: begin
                    vd_failed = !is_lf && (col_reg >= COL_W'(URI_BYTES - 1));
                    if (is_lf) begin
                        vd_seg   = seg_inc;
                        vd_phase = (seg_inc >= SEG_W'(MAX_SEGMENTS)) ? PH_DONE : PH_TAG;
                    end
                end
                default: begin
                    vd_failed = 1'b1;
                end
            endcase
        end
        vd_ok = !vd_failed && (vd_phase == PH_DONE) && (vd_seg != '0);
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            col_reg        <= '0;
            acc_reg        <= '0;
            digit_seen_reg <= 1'b0;
            cand_reg       <= 2'b11;
            seg_reg        <= '0;
            failed_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            col_reg        <= col_next;
            acc_reg        <= acc_next;
            digit_seen_reg <= digit_seen_next;
            cand_reg       <= cand_next;
            seg_reg        <= seg_next;
            failed_reg     <= failed_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

>>> sv/mpp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mpp_checker (
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      s_valid,
    input wire                      s_ready,
    input wire mpp_pkg::in_item_t   s_data,
    input wire                      m_valid,
    input wire                      m_ready,
    input wire mpp_pkg::out_item_t  m_data
);
    import mpp_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // last byte gives a verdict in the next cycle
    a_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.is_last |=> m_valid && (m_data.kind == KIND_VERDICT))
        else $error("last byte without verdict");

    // accepted flag only on a verdict, with a legal segment count
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accepted |-> (m_data.kind == KIND_VERDICT) &&
            (m_data.value != 32'd0) && (m_data.value <= 32'(MAX_SEGMENTS)))
        else $error("bad accept verdict");

    // a reject carries a zero count
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_VERDICT) && !m_data.accepted |->
            (m_data.value == 32'd0))
        else $error("reject verdict with nonzero count");

endmodule

bind media_playlist_parser_core mpp_checker u_mpp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
